[hdl/csvrdr_pkg.sv]
// Shared types and byte constants for the CSV record delimiter rewriter.
// No dependencies; every other file in hdl/ imports this package.
`default_nettype none

package csvrdr_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] BYTE_NUL   = 8'h00;
  localparam logic [ByteW-1:0] BYTE_LF    = 8'h0A;
  localparam logic [ByteW-1:0] BYTE_CR    = 8'h0D;
  localparam logic [ByteW-1:0] BYTE_SUB   = 8'h1A;
  localparam logic [ByteW-1:0] BYTE_QUOTE = 8'h22;

  // Outcome of scanning one beat: whether a byte goes out, and which.
  typedef struct packed {
    logic             emit;
    logic [ByteW-1:0] data;
  } scan_res_t;

endpackage

`default_nettype wire

[hdl/csv_record_delimiter_rewriter.sv]
// CSV record delimiter rewriter, top level.
// Depends on csvrdr_pkg, csvrdr_ireg, csvrdr_scan and csvrdr_oreg.
//
// Usage:
//   Raw CSV text enters one byte per beat on the in_ stream channel. Rewritten
//   bytes leave on the out_ stream channel: 0x00 ends a record outside quotes,
//   0x1A replaces NUL, a CR LF pair collapses to one 0x00, and line ends inside
//   quoted cells pass unchanged. Some input beats produce no output beat (the
//   LF of a CR LF pair, and every byte of a dropped header line).
//   cfg_wr_en with cfg_wr_data sets the header-drop mode; write it only while
//   no beats are in flight.
//   An input beat passes through the input register, then the scan step, then
//   the output register. Throughput is one byte per cycle while the receiver
//   takes every beat, set by the combinational scan step between the two registers.
//   When the receiver stalls, the output register holds its beat, and in_tready falls
//   as soon as the input register also holds a beat that cannot move on, so no beat is
//   lost. Reset empties both registers, clears the header-drop mode, returns
//   the scanner to outside-quotes and marks the header line as not yet seen.
`default_nettype none

module csv_record_delimiter_rewriter
  import csvrdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,  // bit 0: drop_first_line
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [ByteW-1:0] in_tdata,     // [7:0] in_byte
  output logic                  out_tvalid,
  input  wire logic             out_tready,
  output logic [ByteW-1:0]      out_tdata     // [7:0] out_byte
);

  logic             hold_valid;
  logic [ByteW-1:0] hold_byte;
  logic             room;
  logic             take;
  scan_res_t        res;

  // A held beat moves on when the output register has room for it.
  assign take = hold_valid && room;

  csvrdr_ireg u_ireg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .hold_valid (hold_valid),
    .hold_byte  (hold_byte),
    .take       (take)
  );

  csvrdr_scan u_scan (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .scan_byte   (hold_byte),
    .step        (take),
    .res         (res)
  );

  csvrdr_oreg u_oreg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (take),
    .res        (res),
    .room       (room),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

[hdl/csvrdr_ireg.sv]
// Input register stage: captures one beat from the slave side.
// Depends on csvrdr_pkg for the byte width.
`default_nettype none

module csvrdr_ireg
  import csvrdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_tvalid,
  output logic                  in_tready,
  input  wire logic [ByteW-1:0] in_tdata,
  output logic                  hold_valid,
  output logic [ByteW-1:0]      hold_byte,
  input  wire logic             take
);

  logic             valid_r;
  logic [ByteW-1:0] byte_r;

  // The stage refills in the same cycle that its beat moves on.
  assign in_tready  = !valid_r || take;
  assign hold_valid = valid_r;
  assign hold_byte  = byte_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      byte_r <= in_tdata;
    end
  end

endmodule

`default_nettype wire

[hdl/csvrdr_scan.sv]
// Quote-aware scanner: holds the scan mode, header flag and configuration bit,
// and decides per beat what byte, if any, goes out. Depends on csvrdr_pkg.
`default_nettype none

module csvrdr_scan
  import csvrdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,
  input  wire logic [ByteW-1:0] scan_byte,
  input  wire logic             step,
  output scan_res_t             res
);

  typedef enum logic [1:0] {
    FRESH       = 2'd0,
    AFTER_CR    = 2'd1,
    AFTER_QUOTE = 2'd2,
    QUOTED      = 2'd3
  } mode_t;

  mode_t mode_r, mode_nxt;
  logic  pend_r, pend_nxt;
  logic  drop_r;

  always_comb begin
    mode_nxt = mode_r;
    pend_nxt = pend_r;
    res.emit = 1'b1;
    res.data = scan_byte;

    if (drop_r && pend_r) begin
      // Header line: swallow everything up to the first CR or LF.
      res.emit = 1'b0;
      if (scan_byte == BYTE_LF) begin
        pend_nxt = 1'b0;
      end else if (scan_byte == BYTE_CR) begin
        pend_nxt = 1'b0;
        mode_nxt = AFTER_CR;
      end
    end else if (mode_r == QUOTED) begin
      if (scan_byte == BYTE_QUOTE) begin
        mode_nxt = AFTER_QUOTE;
      end else if (scan_byte == BYTE_NUL) begin
        res.data = BYTE_SUB;
      end
    end else if (mode_r == AFTER_QUOTE && scan_byte == BYTE_QUOTE) begin
      // Doubled quote keeps the cell open.
      mode_nxt = QUOTED;
    end else if (mode_r == AFTER_CR && scan_byte == BYTE_LF) begin
      mode_nxt = FRESH;
      res.emit = 1'b0;
    end else begin
      // Outside quotes, including a cell that the last quote just closed.
      mode_nxt = FRESH;
      unique case (scan_byte)
        BYTE_QUOTE: mode_nxt = QUOTED;
        BYTE_LF:    res.data = BYTE_NUL;
        BYTE_CR: begin
          mode_nxt = AFTER_CR;
          res.data = BYTE_NUL;
        end
        BYTE_NUL:   res.data = BYTE_SUB;
        default:    res.data = scan_byte;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= FRESH;
      pend_r <= 1'b1;
      drop_r <= 1'b0;
    end else begin
      if (step) begin
        mode_r <= mode_nxt;
        pend_r <= pend_nxt;
      end
      if (cfg_wr_en) begin
        drop_r <= cfg_wr_data;
      end
    end
  end

endmodule

`default_nettype wire

[hdl/csvrdr_oreg.sv]
// Output register stage: holds one result beat for the master side.
// Depends on csvrdr_pkg for the result struct.
`default_nettype none

module csvrdr_oreg
  import csvrdr_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        load,
  input  wire scan_res_t   res,
  output logic             room,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [ByteW-1:0] out_tdata
);

  logic             valid_r;
  logic [ByteW-1:0] data_r;

  assign room       = !valid_r || out_tready;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (room) begin
      valid_r <= load && res.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (room && load && res.emit) begin
      data_r <= res.data;
    end
  end

endmodule

`default_nettype wire

[tb/sv/csvrdr_stream_checker.sv]
// Scoreboard for the CSV record delimiter rewriter: watches the config port and both
// stream channels, predicts each output byte and compares it in order.
// Depends on csvrdr_pkg for the byte width, the byte constants and scan_res_t.
module csvrdr_stream_checker
  import csvrdr_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_wr_data,
  input  wire logic             in_tvalid,
  input  wire logic             in_tready,
  input  wire logic [ByteW-1:0] in_tdata,
  input  wire logic             out_tvalid,
  input  wire logic             out_tready,
  input  wire logic [ByteW-1:0] out_tdata,
  output int unsigned           fail_count,
  output int unsigned           expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [1:0] {
    SCAN_FRESH,
    SCAN_AFTER_CR,
    SCAN_AFTER_QUOTE,
    SCAN_QUOTED
  } scan_mode_t;

  scan_mode_t       scan_mode_q;
  logic             header_left;
  logic             skip_header_en;
  logic [ByteW-1:0] pending_out_bytes [$];

  // Byte seen while outside quotes; also used when a quote or CR state falls through.
  function automatic scan_res_t outside_quotes(input logic [ByteW-1:0] b);
    scan_res_t r;
    r.emit      = 1'b1;
    r.data      = b;
    scan_mode_q = SCAN_FRESH;
    case (b)
      BYTE_QUOTE: scan_mode_q = SCAN_QUOTED;
      BYTE_LF:    r.data = BYTE_NUL;
      BYTE_CR: begin
        scan_mode_q = SCAN_AFTER_CR;
        r.data      = BYTE_NUL;
      end
      BYTE_NUL:   r.data = BYTE_SUB;
      default: ;
    endcase
    return r;
  endfunction

  function automatic scan_res_t rewrite_byte(input logic [ByteW-1:0] b);
    scan_res_t r;
    r = '0;
    // The header line is swallowed whole, quotes included.
    if (skip_header_en && header_left) begin
      if (b == BYTE_LF || b == BYTE_CR) begin
        header_left = 1'b0;
        if (b == BYTE_CR) scan_mode_q = SCAN_AFTER_CR;
      end
      return r;
    end
    case (scan_mode_q)
      SCAN_QUOTED: begin
        r.emit = 1'b1;
        r.data = (b == BYTE_NUL) ? BYTE_SUB : b;
        if (b == BYTE_QUOTE) scan_mode_q = SCAN_AFTER_QUOTE;
      end
      SCAN_AFTER_QUOTE: begin
        if (b == BYTE_QUOTE) begin
          r.emit      = 1'b1;
          r.data      = b;
          scan_mode_q = SCAN_QUOTED;
        end else begin
          r = outside_quotes(b);
        end
      end
      SCAN_AFTER_CR: begin
        if (b == BYTE_LF) scan_mode_q = SCAN_FRESH;
        else r = outside_quotes(b);
      end
      default: r = outside_quotes(b);
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    scan_res_t        res;
    logic [ByteW-1:0] want;
    if (!rst_n) begin
      scan_mode_q    = SCAN_FRESH;
      header_left    = 1'b1;
      skip_header_en = 1'b0;
      pending_out_bytes.delete();
    end else begin
      // Output first: a beat leaving now always belongs to an earlier input.
      if (out_tvalid && out_tready) begin
        if (pending_out_bytes.size() == 0) begin
          $error("out_byte: unexpected beat 0x%02h with nothing expected", out_tdata);
          fail_count++;
        end else begin
          want = pending_out_bytes.pop_front();
          if (out_tdata !== want) begin
            $error("out_byte: expected 0x%02h, got 0x%02h", want, out_tdata);
            fail_count++;
          end
        end
      end
      if (cfg_wr_en) skip_header_en = cfg_wr_data;
      if (in_tvalid && in_tready) begin
        res = rewrite_byte(in_tdata);
        if (res.emit) pending_out_bytes.push_back(res.data);
      end
    end
    expected_left = pending_out_bytes.size();
  end

endmodule

[tb/sv/csv_record_delimiter_rewriter_tb.sv]
// Testbench top for the CSV record delimiter rewriter: clock, reset, byte stimulus,
// random back-pressure and the verdict. Depends on csvrdr_pkg, the RTL and
// csvrdr_stream_checker, which does all prediction and comparison.
module csv_record_delimiter_rewriter_tb;
  import csvrdr_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomBytes = 1300;
  localparam int unsigned Phases      = 4;
  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned DrainCycles = 4;

  localparam logic [ByteW-1:0] BYTE_COMMA = 8'h2C;

  // Directed run with the header drop off: a mix of byte kinds in every scan state.
  localparam logic [ByteW-1:0] DirectedBytes [27] = '{
    BYTE_NUL, 8'hFF, BYTE_COMMA, BYTE_LF, BYTE_CR, BYTE_LF, BYTE_CR, 8'h78,
    BYTE_QUOTE, 8'h61, BYTE_CR, BYTE_LF, BYTE_NUL, BYTE_QUOTE, BYTE_QUOTE, 8'h62,
    BYTE_QUOTE, BYTE_LF, BYTE_QUOTE, BYTE_QUOTE, BYTE_CR, 8'h7A,
    BYTE_QUOTE, 8'h01, BYTE_QUOTE, BYTE_NUL, BYTE_LF
  };

  // Header line with a stray quote, ended by CR LF, then one empty record.
  localparam logic [ByteW-1:0] HeaderBytes [5] = '{
    8'h68, BYTE_QUOTE, BYTE_CR, BYTE_LF, BYTE_LF
  };

  logic             clk         = 1'b0;
  logic             rst_n       = 1'b0;
  logic             cfg_wr_en   = 1'b0;
  logic             cfg_wr_data = 1'b0;
  logic             in_tvalid   = 1'b0;
  logic             in_tready;
  logic [ByteW-1:0] in_tdata    = '0;
  logic             out_tvalid;
  logic             out_tready  = 1'b0;
  logic [ByteW-1:0] out_tdata;

  int unsigned fail_count;
  int unsigned expected_left;
  int unsigned cycle_count = 0;
  int unsigned bytes_sent  = 0;
  bit          no_idle     = 1'b0;

  always #5 clk = ~clk;

  csv_record_delimiter_rewriter i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  csvrdr_stream_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .fail_count    (fail_count),
    .expected_left (expected_left)
  );

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Receiver: a random stall before each output beat, none while no_idle is set.
  initial begin : sink
    int unsigned stall;
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 7);
      if (stall != 0) begin
        out_tready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready = 1'b1;
      do @(posedge clk); while (!out_tvalid);
      @(negedge clk);
    end
  end

  // tvalid stays high across back-to-back beats; it only drops for a gap.
  task automatic send_byte(input logic [ByteW-1:0] b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata  = b;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
    bytes_sent++;
  endtask

  // A byte with no result may still sit in the pipe when the queue runs dry.
  task automatic write_drop_mode(input logic v);
    in_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
  endtask

  function automatic logic [ByteW-1:0] cell_byte(input bit quoted);
    case ($urandom_range(0, 9))
      0:       return BYTE_NUL;
      1:       return ByteW'($urandom_range(0, 255));
      2:       return quoted ? BYTE_CR : BYTE_COMMA;
      3:       return quoted ? BYTE_LF : 8'h20;
      4:       return quoted ? BYTE_COMMA : 8'h2E;
      default: return ByteW'($urandom_range(8'h30, 8'h7A));
    endcase
  endfunction

  task automatic send_record();
    int unsigned cells;
    int unsigned len;
    bit          quoted;
    cells = $urandom_range(1, 4);
    for (int c = 0; c < cells; c++) begin
      if (c != 0) send_byte(BYTE_COMMA);
      quoted = 1'($urandom_range(0, 1));
      len    = $urandom_range(0, 5);
      if (quoted) send_byte(BYTE_QUOTE);
      repeat (len) begin
        if (quoted && $urandom_range(0, 5) == 0) begin
          send_byte(BYTE_QUOTE);
          send_byte(BYTE_QUOTE);
        end else begin
          send_byte(cell_byte(quoted));
        end
      end
      if (quoted) send_byte(BYTE_QUOTE);
    end
    case ($urandom_range(0, 2))
      0: send_byte(BYTE_LF);
      1: send_byte(BYTE_CR);
      default: begin
        send_byte(BYTE_CR);
        send_byte(BYTE_LF);
      end
    endcase
  endtask

  // Noise leaves quotes unbalanced and line ends half-finished on purpose.
  task automatic send_noise();
    int unsigned n;
    n = $urandom_range(1, 8);
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       send_byte(BYTE_QUOTE);
        1:       send_byte(BYTE_CR);
        2:       send_byte(BYTE_LF);
        3:       send_byte(BYTE_NUL);
        default: send_byte(ByteW'($urandom_range(0, 255)));
      endcase
    end
  endtask

  initial begin
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    write_drop_mode(1'b0);
    foreach (DirectedBytes[i]) send_byte(DirectedBytes[i]);
    write_drop_mode(1'b1);
    foreach (HeaderBytes[i]) send_byte(HeaderBytes[i]);

    bytes_sent = 0;
    for (int p = 0; p < Phases; p++) begin
      write_drop_mode(p[0]);
      while (bytes_sent < (p + 1) * RandomBytes / Phases) begin
        no_idle = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) send_noise();
        else send_record();
      end
      no_idle = 1'b0;
    end

    in_tvalid = 1'b0;
    while (expected_left != 0) @(negedge clk);
    repeat (DrainCycles * 4) @(negedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
